// ----- hdl/timebase_ticks_to_nanoseconds_macros.svh -----
// Assertion helpers shared by the timebase converter modules.
// Each macro expects a clock named clk and a synchronous reset named rst.
`ifndef TIMEBASE_TICKS_TO_NANOSECONDS_MACROS_SVH
`define TIMEBASE_TICKS_TO_NANOSECONDS_MACROS_SVH

// Same-cycle implication: whenever ante holds, cons holds too.
`define TBNS_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication: whenever ante holds, cons holds in the next cycle.
`define TBNS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/tbns_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package tbns_pkg;

  // Field and register widths.
  localparam int TickWidth  = 64;
  localparam int RatioWidth = 32;
  localparam int HalfWidth  = 32;

  // Configuration register indexes.
  localparam int CfgIndexWidth = 1;
  localparam logic [CfgIndexWidth-1:0] RegNumerator   = 1'd0;
  localparam logic [CfgIndexWidth-1:0] RegDenominator = 1'd1;

  // Restoring divider: one quotient bit per cycle.
  localparam int DivSteps      = TickWidth;
  localparam int DivCountWidth = $clog2(DivSteps);

  // Status that the divider reports to its user.
  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

endpackage

`default_nettype wire

// ----- hdl/tbns_div.sv -----
`timescale 1ns / 1ps
`default_nettype none

`include "timebase_ticks_to_nanoseconds_macros.svh"

// Radix-2 restoring divider, 64-bit dividend by 32-bit nonzero divisor.
// The dividend shifts out one bit per cycle while quotient bits shift in.
module tbns_div (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             start,
  input  wire logic [tbns_pkg::TickWidth-1:0]   dividend,
  input  wire logic [tbns_pkg::RatioWidth-1:0]  divisor,
  output tbns_pkg::div_status_t                 status,
  output logic      [tbns_pkg::TickWidth-1:0]   quotient,
  output logic      [tbns_pkg::RatioWidth-1:0]  remainder
);

  logic [tbns_pkg::TickWidth-1:0]     shift_reg;
  logic [tbns_pkg::RatioWidth-1:0]    rem;
  logic [tbns_pkg::RatioWidth-1:0]    dsr;
  logic [tbns_pkg::DivCountWidth-1:0] count;
  logic                               busy;
  logic                               done;

  logic [tbns_pkg::RatioWidth:0]   rem_shift;
  logic [tbns_pkg::RatioWidth:0]   diff;
  logic                            qbit;
  logic [tbns_pkg::RatioWidth-1:0] rem_next;

  // The partial remainder stays below the divisor, so the shifted value is
  // below twice the divisor and a single subtract restores it.
  always_comb begin
    rem_shift = {rem, shift_reg[tbns_pkg::TickWidth-1]};
    diff      = rem_shift - {1'b0, dsr};
    qbit      = (rem_shift >= {1'b0, dsr});
    rem_next  = qbit ? diff[tbns_pkg::RatioWidth-1:0]
                     : rem_shift[tbns_pkg::RatioWidth-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        shift_reg <= dividend;
        dsr       <= divisor;
        rem       <= '0;
        count     <= '0;
        busy      <= 1'b1;
      end else if (busy) begin
        shift_reg <= {shift_reg[tbns_pkg::TickWidth-2:0], qbit};
        rem       <= rem_next;
        count     <= count + 1'b1;
        if (count == tbns_pkg::DivCountWidth'(tbns_pkg::DivSteps - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign status.busy = busy;
  assign status.done = done;
  assign quotient    = shift_reg;
  assign remainder   = rem;

  `TBNS_ASSERT_SAME(a_no_restart, start, !busy, "divider started while busy")
  `TBNS_ASSERT_SAME(a_done_after_busy, done, $past(busy), "done without a running division")
  `TBNS_ASSERT_NEXT(a_busy_ends_in_done, busy && !start, busy || done, "division dropped")

endmodule

`default_nettype wire

// ----- hdl/timebase_ticks_to_nanoseconds.sv -----
// Tick-to-nanosecond converter.
// Requests arrive on the s_ stream as raw 64-bit tick counter samples. The first
// request after reset is latched as the origin and gives zero. Every request gives
// one 64-bit result on the m_ stream: ticks since the origin times
// ratio_numerator / ratio_denominator, wrapping modulo 2^64; a zero denominator
// with a nonzero numerator gives all ones instead. The ratio registers are
// written through cfg_wen / cfg_index / cfg_data; the user must write them only
// while the block is idle, which the block itself does not enforce. Both reset to 1.
// When the numerator equals the denominator, the denominator is one or the
// denominator is zero, the result is formed in the select state without division.
// Otherwise two 64-bit divisions run on one shared radix-2 divider at one
// quotient bit per cycle. The block takes one request at a time; the next one is
// taken as soon as the previous result has been moved into the output register.
// A stalled receiver holds the result in the output register; a new request can
// still be taken and worked on, and waits at its end for the register to free.
// Reset clears the origin and all handshake state and sets both ratio registers to 1.
`timescale 1ns / 1ps
`default_nettype none

`include "timebase_ticks_to_nanoseconds_macros.svh"

module timebase_ticks_to_nanoseconds (
  input  wire logic                                clk,
  input  wire logic                                rst,
  // Configuration write port.
  input  wire logic                                cfg_wen,
  input  wire logic [tbns_pkg::CfgIndexWidth-1:0]  cfg_index,
  input  wire logic [tbns_pkg::RatioWidth-1:0]     cfg_data,
  // Sample requests.
  input  wire logic                                s_tvalid,
  output logic                                     s_tready,
  input  wire logic [tbns_pkg::TickWidth-1:0]      s_tdata,  // [63:0] tick_sample
  // Results.
  output logic                                     m_tvalid,
  input  wire logic                                m_tready,
  output logic      [tbns_pkg::TickWidth-1:0]      m_tdata   // [63:0] elapsed_ns
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL_HI,
    S_MUL_LO,
    S_SEL,
    S_DIV_HI,
    S_DIV_LO,
    S_DONE
  } state_t;

  state_t state;

  logic [tbns_pkg::RatioWidth-1:0] ratio_numerator;
  logic [tbns_pkg::RatioWidth-1:0] ratio_denominator;

  logic                            origin_latched;
  logic [tbns_pkg::TickWidth-1:0]  origin_ticks;
  logic [tbns_pkg::TickWidth-1:0]  elapsed;
  logic [tbns_pkg::TickWidth-1:0]  hi_prod;
  logic [tbns_pkg::TickWidth-1:0]  lo_prod;
  logic [tbns_pkg::HalfWidth-1:0]  q_hi;
  logic [tbns_pkg::TickWidth-1:0]  result;

  logic                            in_accept;
  logic                            out_load;
  logic [tbns_pkg::HalfWidth-1:0]  mul_a;
  logic [tbns_pkg::TickWidth-1:0]  mul_prod;

  logic                            div_start;
  logic [tbns_pkg::TickWidth-1:0]  div_dividend;
  tbns_pkg::div_status_t           div_stat;
  logic [tbns_pkg::TickWidth-1:0]  div_quot;
  logic [tbns_pkg::RatioWidth-1:0] div_rem;

  assign s_tready  = (state == S_IDLE);
  assign in_accept = s_tvalid && s_tready;

  // In the done state, the output register loads when it is empty or being emptied this cycle.
  assign out_load  = (state == S_DONE) && (!m_tvalid || m_tready);

  // One 32 by 32 multiplier serves both halves of the elapsed count.
  assign mul_a    = (state == S_MUL_HI) ? elapsed[tbns_pkg::TickWidth-1:tbns_pkg::HalfWidth]
                                        : elapsed[tbns_pkg::HalfWidth-1:0];
  assign mul_prod = {{tbns_pkg::HalfWidth{1'b0}}, ratio_numerator}
                  * {{tbns_pkg::HalfWidth{1'b0}}, mul_a};

  // The first division takes the high product. The second takes the first
  // remainder shifted up a half word plus the low product, wrapping at 64 bits.
  always_comb begin
    div_start    = 1'b0;
    div_dividend = hi_prod;
    if (state == S_SEL) begin
      div_start = (ratio_numerator != ratio_denominator)
               && (ratio_denominator > tbns_pkg::RatioWidth'(1));
    end else if (state == S_DIV_HI) begin
      div_start    = div_stat.done;
      div_dividend = {div_rem, {tbns_pkg::HalfWidth{1'b0}}} + lo_prod;
    end
  end

  tbns_div u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (div_dividend),
    .divisor   (ratio_denominator),
    .status    (div_stat),
    .quotient  (div_quot),
    .remainder (div_rem)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= S_IDLE;
      m_tvalid          <= 1'b0;
      origin_latched    <= 1'b0;
      ratio_numerator   <= tbns_pkg::RatioWidth'(1);
      ratio_denominator <= tbns_pkg::RatioWidth'(1);
    end else begin
      if (cfg_wen) begin
        unique case (cfg_index)
          tbns_pkg::RegNumerator:   ratio_numerator   <= cfg_data;
          tbns_pkg::RegDenominator: ratio_denominator <= cfg_data;
          default: ;
        endcase
      end

      if (out_load) begin
        m_tvalid <= 1'b1;
        m_tdata  <= result;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (in_accept) begin
            // The very first sample becomes the origin, so it reads as zero.
            if (!origin_latched) begin
              origin_ticks   <= s_tdata;
              origin_latched <= 1'b1;
              elapsed        <= '0;
            end else begin
              elapsed <= s_tdata - origin_ticks;
            end
            state <= S_MUL_HI;
          end
        end
        S_MUL_HI: begin
          hi_prod <= mul_prod;
          state   <= S_MUL_LO;
        end
        S_MUL_LO: begin
          lo_prod <= mul_prod;
          state   <= S_SEL;
        end
        S_SEL: begin
          priority if (ratio_numerator == ratio_denominator) begin
            result <= elapsed;
            state  <= S_DONE;
          end else if (ratio_denominator == tbns_pkg::RatioWidth'(1)) begin
            // Full 64-bit product, modulo 2^64, from the two half products.
            result <= lo_prod + {hi_prod[tbns_pkg::HalfWidth-1:0],
                                 {tbns_pkg::HalfWidth{1'b0}}};
            state  <= S_DONE;
          end else if (ratio_denominator == '0) begin
            result <= '1;
            state  <= S_DONE;
          end else begin
            state <= S_DIV_HI;
          end
        end
        S_DIV_HI: begin
          if (div_stat.done) begin
            q_hi  <= div_quot[tbns_pkg::HalfWidth-1:0];
            state <= S_DIV_LO;
          end
        end
        S_DIV_LO: begin
          if (div_stat.done) begin
            result <= {q_hi, {tbns_pkg::HalfWidth{1'b0}}} + div_quot;
            state  <= S_DONE;
          end
        end
        S_DONE: begin
          // Wait here until the output register is free or being emptied.
          if (out_load) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `TBNS_ASSERT_NEXT(a_accept_starts_mul, in_accept, state == S_MUL_HI, "request not started")
  `TBNS_ASSERT_SAME(a_div_running, state == S_DIV_HI || state == S_DIV_LO,
                    div_stat.busy || div_stat.done, "divider idle during division")
  `TBNS_ASSERT_SAME(a_result_from_done, $rose(m_tvalid), $past(state == S_DONE),
                    "result shown outside done state")

endmodule

`default_nettype wire

// ----- bench/tick_ns_checker.sv -----
`timescale 1ns / 1ps

// Watches the ratio write port and both streams of the tick converter,
// predicts every result and compares it with what leaves the block.
module tick_ns_checker (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                cfg_wen,
  input  wire logic [tbns_pkg::CfgIndexWidth-1:0]  cfg_index,
  input  wire logic [tbns_pkg::RatioWidth-1:0]     cfg_data,
  input  wire logic                                s_tvalid,
  input  wire logic                                s_tready,
  input  wire logic [tbns_pkg::TickWidth-1:0]      s_tdata,   // [63:0] tick_sample
  input  wire logic                                m_tvalid,
  input  wire logic                                m_tready,
  input  wire logic [tbns_pkg::TickWidth-1:0]      m_tdata,   // [63:0] elapsed_ns
  output int                                       errors,
  output int                                       outstanding,
  output int                                       results_checked
);

  logic [tbns_pkg::RatioWidth-1:0] numer = tbns_pkg::RatioWidth'(1);
  logic [tbns_pkg::RatioWidth-1:0] denom = tbns_pkg::RatioWidth'(1);
  logic [tbns_pkg::TickWidth-1:0]  origin = '0;
  logic                            origin_taken = 1'b0;
  logic [tbns_pkg::TickWidth-1:0]  pending_ns[$];
  logic [tbns_pkg::TickWidth-1:0]  oldest_ns;

  initial begin
    errors = 0;
    outstanding = 0;
    results_checked = 0;
  end

  // Elapsed ticks times num / den, wrapping modulo 2^64 at every step; all ones when den is zero and num is not.
  function automatic logic [tbns_pkg::TickWidth-1:0] ticks_to_ns(
      input logic [tbns_pkg::TickWidth-1:0]  elapsed,
      input logic [tbns_pkg::RatioWidth-1:0] num,
      input logic [tbns_pkg::RatioWidth-1:0] den);
    logic [tbns_pkg::TickWidth-1:0] num_w, den_w, hi_prod, lo_prod, q_hi, r_hi;
    num_w = {32'd0, num};
    den_w = {32'd0, den};
    if (num_w == den_w) return elapsed;
    if (den_w == 64'd1) return elapsed * num_w;
    if (den_w == 64'd0) return '1;
    hi_prod = num_w * {32'd0, elapsed[63:32]};
    lo_prod = num_w * {32'd0, elapsed[31:0]};
    q_hi = hi_prod / den_w;
    r_hi = hi_prod - q_hi * den_w;
    return (q_hi << tbns_pkg::HalfWidth)
         + (((r_hi << tbns_pkg::HalfWidth) + lo_prod) / den_w);
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      numer = tbns_pkg::RatioWidth'(1);
      denom = tbns_pkg::RatioWidth'(1);
      origin = '0;
      origin_taken = 1'b0;
      pending_ns.delete();
    end else begin
      if (cfg_wen) begin
        case (cfg_index)
          tbns_pkg::RegNumerator:   numer = cfg_data;
          tbns_pkg::RegDenominator: denom = cfg_data;
          default: ;
        endcase
      end
      // Results are matched before new requests are queued, so a result that
      // appears in the same cycle as its own request is caught as unexpected.
      if (m_tvalid && m_tready) begin
        if (pending_ns.size() == 0) begin
          if (errors < 10)
            $display("%0t: unexpected result elapsed_ns %h", $realtime, m_tdata);
          errors++;
        end else begin
          oldest_ns = pending_ns.pop_front();
          if (m_tdata !== oldest_ns) begin
            if (errors < 10)
              $display("%0t: result %0d elapsed_ns expected %h, got %h",
                       $realtime, results_checked, oldest_ns, m_tdata);
            errors++;
          end
          results_checked++;
        end
      end
      if (s_tvalid && s_tready) begin
        if (!origin_taken) begin
          origin = s_tdata;
          origin_taken = 1'b1;
        end
        pending_ns.push_back(ticks_to_ns(s_tdata - origin, numer, denom));
      end
    end
    outstanding = pending_ns.size();
  end

endmodule

// ----- bench/testbench.sv -----
`timescale 1ns / 1ps

// Stimulus and verdict for the tick-to-nanosecond converter.
//
// The top drives the ratio write port and the sample stream, and throttles
// the result stream. All prediction and comparison lives in tick_ns_checker,
// which reports how many results are still owed and how many failures it saw.
//
// Every input changes on the falling clock edge; the block and the checker
// both see them at the rising edge, so nothing depends on event order.
module testbench;

  // The longest planned quiet stretch is the deliberate receiver hold-off below.
  localparam int HoldCycles  = 600;
  localparam int QuietLimit  = 5000;
  localparam int DrainCycles = 160;

  logic                               clk = 1'b0;
  logic                               rst = 1'b1;
  logic                               cfg_wen = 1'b0;
  logic [tbns_pkg::CfgIndexWidth-1:0] cfg_index = tbns_pkg::RegNumerator;
  logic [tbns_pkg::RatioWidth-1:0]    cfg_data = '0;
  logic                               s_tvalid = 1'b0;
  logic                               s_tready;
  logic [tbns_pkg::TickWidth-1:0]     s_tdata = '0;
  logic                               m_tvalid;
  logic                               m_tready = 1'b0;
  logic [tbns_pkg::TickWidth-1:0]     m_tdata;

  int errors;
  int outstanding;
  int results_checked;

  // Idle rates in percent, set per phase by the stimulus process.
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  bit hold_request = 1'b0;
  int requests_sent = 0;
  int ratio_settings = 0;
  int quiet_cycles = 0;

  always #5 clk = ~clk;

  timebase_ticks_to_nanoseconds dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_wen  (cfg_wen),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  tick_ns_checker u_check (
    .clk            (clk),
    .rst            (rst),
    .cfg_wen        (cfg_wen),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .s_tvalid       (s_tvalid),
    .s_tready       (s_tready),
    .s_tdata        (s_tdata),
    .m_tvalid       (m_tvalid),
    .m_tready       (m_tready),
    .m_tdata        (m_tdata),
    .errors         (errors),
    .outstanding    (outstanding),
    .results_checked(results_checked)
  );

  // The run is ended once quiet_cycles, reset on every stream transfer, reaches QuietLimit. That covers
  // a hung divider as well as a result that never gets out.
  always @(posedge clk) begin
    if (!rst) begin
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= QuietLimit) begin
        $display("testbench: no stream activity for %0d cycles", QuietLimit);
        $display("testbench: done, errors");
        $finish;
      end
    end
  end

  // Result side. Normally ready is drawn at random each cycle; on request it
  // is held low for a long stretch so the output register and the working
  // request both fill and the block has to drop s_tready.
  initial begin
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        repeat (HoldCycles) begin
          m_tready <= 1'b0;
          @(negedge clk);
        end
      end
      m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // Offers one sample request and returns on the falling edge after it has
  // been taken. Valid is left high so back-to-back requests need no gap.
  task automatic send_tick(input logic [tbns_pkg::TickWidth-1:0] sample);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= sample;
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
    requests_sent++;
  endtask

  // Changes the ratio once every owed result has left the block. Each result
  // belongs to exactly one request, so an empty scoreboard means an idle block.
  task automatic set_ratio(input logic [tbns_pkg::RatioWidth-1:0] num,
                           input logic [tbns_pkg::RatioWidth-1:0] den);
    s_tvalid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    cfg_wen   <= 1'b1;
    cfg_index <= tbns_pkg::RegNumerator;
    cfg_data  <= num;
    @(negedge clk);
    cfg_index <= tbns_pkg::RegDenominator;
    cfg_data  <= den;
    @(negedge clk);
    cfg_wen <= 1'b0;
    ratio_settings++;
  endtask

  // The origin is the zero sample sent first, so small values give short
  // elapsed counts and values near the top of the range give wrapped ones.
  function automatic logic [tbns_pkg::TickWidth-1:0] random_tick();
    case ($urandom_range(0, 9))
      0, 1:    return {$urandom, $urandom};
      2, 3, 4: return {32'd0, 12'd0, 20'($urandom)};
      5, 6:    return {32'd0, $urandom};
      7:       return {24'd0, 8'($urandom), $urandom};
      8:       return 64'd0 - {32'd0, 16'd0, 16'($urandom)};
      default: return {1'b1, 31'($urandom), $urandom};
    endcase
  endfunction

  // Picks a ratio: the pass-through, multiply-only and zero-denominator shortcuts,
  // both ends of the 32-bit range, small typical fractions and fully random ones.
  task automatic random_ratio();
    case ($urandom_range(0, 11))
      0:       set_ratio(32'd1, 32'd1);
      1:       set_ratio($urandom, 32'd1);
      2:       begin
        logic [tbns_pkg::RatioWidth-1:0] same;
        same = $urandom;
        set_ratio(same, same);
      end
      3:       set_ratio($urandom_range(1, 1000), 32'd0);
      4:       set_ratio(32'hFFFF_FFFF, 32'hFFFF_FFFE);
      5:       set_ratio(32'd1, 32'hFFFF_FFFF);
      6:       set_ratio($urandom_range(1, 5000), $urandom_range(2, 64));
      7:       set_ratio(32'd0, $urandom_range(2, 100));
      8:       set_ratio($urandom, $urandom_range(2, 16));
      9:       set_ratio(32'hFFFF_FFFF, $urandom);
      default: set_ratio($urandom, $urandom);
    endcase
  endtask

  initial begin
    repeat (7) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed part, at the reset ratio of one first. A zero sample is taken
    // as the origin just like any other value, and the second zero must still
    // give zero rather than being latched again.
    send_tick(64'd0);
    send_tick(64'd0);
    send_tick(64'hFFFF_FFFF_FFFF_FFFF);
    send_tick(64'd1);
    send_tick(64'h8000_0000_0000_0000);
    send_tick(64'h0000_0000_FFFF_FFFF);
    send_tick(64'h0000_0001_0000_0000);
    // Multiply-only path; the full-scale sample wraps the product.
    set_ratio(32'hFFFF_FFFF, 32'd1);
    send_tick(64'hFFFF_FFFF_FFFF_FFFF);
    send_tick(64'h0000_0001_0000_0001);
    // Divide path at its extremes, then a ratio just above one, where the
    // carried remainder and the final shift and add overflow.
    set_ratio(32'd1, 32'hFFFF_FFFF);
    send_tick(64'hFFFF_FFFF_FFFF_FFFF);
    send_tick(64'h0000_0000_FFFF_FFFE);
    set_ratio(32'hFFFF_FFFF, 32'hFFFF_FFFE);
    send_tick(64'hFFFF_FFFF_FFFF_FFFF);
    send_tick(64'h1234_5678_9ABC_DEF0);
    set_ratio(32'd125, 32'd3);
    send_tick(64'd1000);
    send_tick(64'hDEAD_BEEF_0123_4567);
    // Zero denominator: all ones unless the numerator is zero as well, in
    // which case the two count as equal and the count passes through.
    set_ratio(32'd5, 32'd0);
    send_tick(64'd77);
    set_ratio(32'd0, 32'd0);
    send_tick(64'd12345);
    set_ratio(32'd0, 32'd9);
    send_tick(64'hFFFF_FFFF_FFFF_FFFF);
    set_ratio(32'd7, 32'd2);
    send_tick(64'h0000_0003_0000_0005);

    // Random part in three idling phases: a slow receiver, a slow sender,
    // then none at all. Each phase runs through six ratio settings, and the
    // long receiver hold-off is forced in the first and the last phase.
    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 18 : (phase == 1) ? 86 : 0;
      recv_idle_pct = (phase == 0) ? 86 : (phase == 1) ? 18 : 0;
      for (int seg = 0; seg < 6; seg++) begin
        random_ratio();
        if (seg == 2 && phase != 1) hold_request = 1'b1;
        repeat (61) send_tick(random_tick());
      end
    end
    s_tvalid <= 1'b0;

    // Drain, then linger so that a stray extra result would still be seen.
    while (outstanding != 0) @(negedge clk);
    repeat (DrainCycles) @(negedge clk);

    $display("testbench: %0d sample requests over %0d ratio settings, %0d results checked",
             requests_sent, ratio_settings, results_checked);
    if (errors == 0 && outstanding == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: %0d mismatches, %0d results still owed", errors, outstanding);
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule
